[hdl/cbf_pkg.sv]
package cbf_pkg;

    // Storage geometry of the sweep store.
    localparam int DEPTH    = 256;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Register and result field widths.
    localparam int STEP_W   = 17;
    localparam int FREQ_W   = 25;
    localparam int PIDX_W   = 8;
    localparam int PRDATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd10000;

    // Threshold is peak * 46334 / 65536, about 0.707 of the peak.
    localparam int THR_SHIFT = 16;
    localparam logic [THR_SHIFT-1:0] THRESH_MUL = 16'd46334;
    localparam int THR_PROD_W = SAMPLE_W + THR_SHIFT;

    // Interpolation arithmetic.
    localparam int PROD_W = SAMPLE_W + STEP_W;
    localparam int BASE_W = IDX_W + STEP_W;
    localparam int SUM_W  = ((BASE_W > FREQ_W) ? BASE_W : FREQ_W) + 1;
    localparam logic [SUM_W-1:0] FREQ_MAX = SUM_W'((64'd1 << FREQ_W) - 64'd1);

    // The fraction never exceeds step_hz, so the divider needs STEP_W quotient bits.
    localparam int DIV_STEPS = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Scan direction.
    localparam logic SIDE_LO = 1'b0;
    localparam logic SIDE_HI = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic thr_en;
        logic p_zero;
        logic p_peak;
        logic p_inc;
        logic capture;
        logic mul_en;
        logic div_step;
        logic add_en;
        logic side;
        logic publish;
    } cbf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_ok;
        logic hit;
        logic out_busy;
    } cbf_sts_t;

endpackage

[hdl/cbf_ram.sv]
module cbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // One write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/cbf_dp.sv]
module cbf_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbf_pkg::cbf_cmd_t             cmd,
    output cbf_pkg::cbf_sts_t             sts,
    input  logic [cbf_pkg::STEP_W-1:0]    step_hz,
    input  logic [cbf_pkg::SAMPLE_W-1:0]  amplitude,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cbf_pkg::FREQ_W-1:0]    lower_cutoff_hz,
    output logic [cbf_pkg::FREQ_W-1:0]    upper_cutoff_hz,
    output logic                          lower_found,
    output logic                          upper_found,
    output logic [cbf_pkg::PIDX_W-1:0]    peak_index,
    output logic [cbf_pkg::SAMPLE_W-1:0]  peak_value
);

    // Sweep state.
    logic [cbf_pkg::CNT_W-1:0]    cnt_reg;
    logic [cbf_pkg::SAMPLE_W-1:0] peak_reg;
    logic [cbf_pkg::IDX_W-1:0]    pk_idx_reg;

    // Scan and interpolation registers.
    logic [cbf_pkg::SAMPLE_W-1:0] thr_reg;
    logic [cbf_pkg::IDX_W-1:0]    p_reg;
    logic [cbf_pkg::SAMPLE_W-1:0] gap_reg;
    logic [cbf_pkg::SAMPLE_W-1:0] diff_reg;
    logic [cbf_pkg::PROD_W-1:0]   w_reg;
    logic [cbf_pkg::BASE_W-1:0]   base_reg;

    // Per-sweep results before they reach the output register.
    logic [cbf_pkg::FREQ_W-1:0]   lo_hz_reg;
    logic [cbf_pkg::FREQ_W-1:0]   hi_hz_reg;
    logic                         lo_ok_reg;
    logic                         hi_ok_reg;

    // Output register.
    logic                         out_valid_reg;
    logic [cbf_pkg::FREQ_W-1:0]   out_lo_hz_reg;
    logic [cbf_pkg::FREQ_W-1:0]   out_hi_hz_reg;
    logic                         out_lo_ok_reg;
    logic                         out_hi_ok_reg;
    logic [cbf_pkg::PIDX_W-1:0]   out_pidx_reg;
    logic [cbf_pkg::SAMPLE_W-1:0] out_peak_reg;

    logic                          ram_we;
    logic [cbf_pkg::IDX_W-1:0]     p_plus1;
    logic [cbf_pkg::SAMPLE_W-1:0]  smp_a;
    logic [cbf_pkg::SAMPLE_W-1:0]  smp_b;
    logic [cbf_pkg::THR_PROD_W-1:0] thr_prod;
    logic                          rise_hit;
    logic                          fall_hit;
    logic [cbf_pkg::SAMPLE_W:0]    trial;
    logic                          trial_ge;
    logic [cbf_pkg::SAMPLE_W:0]    trial_sub;
    logic [cbf_pkg::STEP_W-1:0]    quot;
    logic [cbf_pkg::SUM_W-1:0]     sum;
    logic [cbf_pkg::FREQ_W-1:0]    freq;

    // Sample store.
    assign ram_we  = cmd.load && (cnt_reg < cbf_pkg::DEPTH_CNT);
    assign p_plus1 = p_reg + 1'b1;

    cbf_ram #(
        .WIDTH (cbf_pkg::SAMPLE_W),
        .DEPTH (cbf_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (cnt_reg[cbf_pkg::IDX_W-1:0]),
        .wdata   (amplitude),
        .raddr_a (p_reg),
        .raddr_b (p_plus1),
        .rdata_a (smp_a),
        .rdata_b (smp_b)
    );

    // Loading: count the samples and keep the first strict maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            peak_reg   <= '0;
            pk_idx_reg <= '0;
        end
        else if (cmd.publish)
        begin
            cnt_reg    <= '0;
            peak_reg   <= '0;
            pk_idx_reg <= '0;
        end
        else if (ram_we)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if ((cnt_reg == '0) || (amplitude > peak_reg))
            begin
                peak_reg   <= amplitude;
                pk_idx_reg <= cnt_reg[cbf_pkg::IDX_W-1:0];
            end
        end
    end

    // Threshold product.
    assign thr_prod = peak_reg * cbf_pkg::THRESH_MUL;

    // Pair bounds and crossing tests.
    assign sts.pair_ok = ((cbf_pkg::CNT_W'(p_reg) + 1'b1) < cnt_reg) &&
                         ((cmd.side == cbf_pkg::SIDE_HI) || (p_reg <= pk_idx_reg));
    assign rise_hit    = (smp_a <= thr_reg) && (smp_b >= thr_reg);
    assign fall_hit    = (smp_a >= thr_reg) && (smp_b <= thr_reg);
    assign sts.hit     = (cmd.side == cbf_pkg::SIDE_HI) ? fall_hit : rise_hit;
    assign sts.out_busy = out_valid_reg && !out_ready;

    // One restoring division step: remainder in the upper bits of w_reg.
    assign trial     = {w_reg[cbf_pkg::PROD_W-1:cbf_pkg::STEP_W],
                        w_reg[cbf_pkg::STEP_W-1]};
    assign trial_ge  = (trial >= {1'b0, diff_reg});
    assign trial_sub = trial - {1'b0, diff_reg};

    // A flat crossing adds no fraction.
    assign quot = (diff_reg == '0) ? '0 : w_reg[cbf_pkg::STEP_W-1:0];
    assign sum  = cbf_pkg::SUM_W'(base_reg) + cbf_pkg::SUM_W'(quot);
    assign freq = (sum > cbf_pkg::FREQ_MAX) ? cbf_pkg::FREQ_MAX[cbf_pkg::FREQ_W-1:0]
                                            : sum[cbf_pkg::FREQ_W-1:0];

    // Scan pointer, threshold and interpolation arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.thr_en)
        begin
            thr_reg   <= thr_prod[cbf_pkg::THR_PROD_W-1:cbf_pkg::THR_SHIFT];
            lo_hz_reg <= '0;
            hi_hz_reg <= '0;
            lo_ok_reg <= 1'b0;
            hi_ok_reg <= 1'b0;
        end

        if (cmd.p_zero)
        begin
            p_reg <= '0;
        end
        else if (cmd.p_peak)
        begin
            p_reg <= pk_idx_reg;
        end
        else if (cmd.p_inc)
        begin
            p_reg <= p_plus1;
        end

        if (cmd.capture)
        begin
            if (cmd.side == cbf_pkg::SIDE_HI)
            begin
                gap_reg  <= smp_a - thr_reg;
                diff_reg <= smp_a - smp_b;
            end
            else
            begin
                gap_reg  <= thr_reg - smp_a;
                diff_reg <= smp_b - smp_a;
            end
        end

        if (cmd.mul_en)
        begin
            w_reg    <= gap_reg * step_hz;
            base_reg <= p_reg * step_hz;
        end
        else if (cmd.div_step)
        begin
            w_reg <= {(trial_ge ? trial_sub[cbf_pkg::SAMPLE_W-1:0]
                                : trial[cbf_pkg::SAMPLE_W-1:0]),
                      w_reg[cbf_pkg::STEP_W-2:0], trial_ge};
        end

        if (cmd.add_en)
        begin
            if (cmd.side == cbf_pkg::SIDE_HI)
            begin
                hi_hz_reg <= freq;
                hi_ok_reg <= 1'b1;
            end
            else
            begin
                lo_hz_reg <= freq;
                lo_ok_reg <= 1'b1;
            end
        end
    end

    // Output register handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_lo_hz_reg <= lo_hz_reg;
            out_hi_hz_reg <= hi_hz_reg;
            out_lo_ok_reg <= lo_ok_reg;
            out_hi_ok_reg <= hi_ok_reg;
            out_pidx_reg  <= pk_idx_reg[cbf_pkg::PIDX_W-1:0];
            out_peak_reg  <= peak_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lower_cutoff_hz = out_lo_hz_reg;
    assign upper_cutoff_hz = out_hi_hz_reg;
    assign lower_found     = out_lo_ok_reg;
    assign upper_found     = out_hi_ok_reg;
    assign peak_index      = out_pidx_reg;
    assign peak_value      = out_peak_reg;

    // The sample count never passes the store depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cbf_pkg::DEPTH_CNT)
        else $error("sample count beyond store depth");

endmodule

[hdl/cbf_ctrl.sv]
module cbf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    input  cbf_pkg::cbf_sts_t  sts,
    output cbf_pkg::cbf_cmd_t  cmd
);

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_THR  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_EV   = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_ADD  = 4'd7;
    localparam logic [3:0] ST_NEXT = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic                          side_reg;
    logic                          side_next;
    logic [cbf_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [cbf_pkg::DIV_CNT_W-1:0] div_cnt_next;

    // State, scan side and divider step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            side_reg    <= cbf_pkg::SIDE_LO;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            side_reg    <= side_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Sequencing: load, threshold, lower scan, upper scan, publish.
    always_comb
    begin
        state_next   = state_reg;
        side_next    = side_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.side     = side_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                cmd.thr_en = 1'b1;
                cmd.p_zero = 1'b1;
                side_next  = cbf_pkg::SIDE_LO;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next = sts.pair_ok ? ST_RD : ST_NEXT;
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                if (sts.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == cbf_pkg::DIV_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_en = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (side_reg == cbf_pkg::SIDE_LO)
                begin
                    side_next  = cbf_pkg::SIDE_HI;
                    cmd.p_peak = 1'b1;
                    state_next = ST_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_LOAD);

    // A last sample always starts the threshold step.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && in_valid && in_last) |=> (state_reg == ST_THR))
        else $error("last sample did not end the sweep");

    // The store is read only for a pair inside the loaded range.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> $past(sts.pair_ok))
        else $error("store read outside the loaded range");

    // The divider never runs past its quotient width.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= cbf_pkg::DIV_LAST))
        else $error("divider step count out of range");

endmodule

[hdl/cutoff_bandwidth_finder_core.sv]
// Minus-3-dB bandwidth finder. Samples of a swept amplitude response (unsigned Q8.8)
// arrive one transaction per cycle while in_ready is high and are written into a
// 256-entry store while the first strict maximum is tracked; a sample with last set
// closes the sweep. The block then takes 0.707 of the peak as threshold, scans pairs
// from index 0 up to the peak for a rising crossing and from the peak onward for a
// falling crossing, and interpolates each crossing to whole hertz using step_hz
// (register 0, byte address 0, reset 10000). After the last sample the sequencer sets
// the threshold, runs a bound check, store read and compare for every sample pair it
// scans, a multiply, 17 steps of the shared restoring divider and an add for each
// crossing found, and one failing bound check for each side without a crossing, and
// finishes with two side changes and a publish once the output register is free. The
// result sits in an output register, so the next sweep can load while it waits to be
// taken.
module cutoff_bandwidth_finder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [cbf_pkg::PRDATA_W-1:0]  pwdata,
    output logic [cbf_pkg::PRDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cbf_pkg::SAMPLE_W-1:0]  amplitude,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cbf_pkg::FREQ_W-1:0]    lower_cutoff_hz,
    output logic [cbf_pkg::FREQ_W-1:0]    upper_cutoff_hz,
    output logic                          lower_found,
    output logic                          upper_found,
    output logic [cbf_pkg::PIDX_W-1:0]    peak_index,
    output logic [cbf_pkg::SAMPLE_W-1:0]  peak_value
);

    logic [cbf_pkg::STEP_W-1:0] step_reg;
    logic                       step_sel;
    cbf_pkg::cbf_cmd_t          cmd;
    cbf_pkg::cbf_sts_t          sts;

    // Configuration register: step_hz is the only register, at word 0.
    assign step_sel = (paddr[2] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = step_sel ? cbf_pkg::PRDATA_W'(step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cbf_pkg::STEP_RESET;
        end
        else if (psel && penable && pwrite && pready && step_sel)
        begin
            step_reg <= pwdata[cbf_pkg::STEP_W-1:0];
        end
    end

    // Sequencer.
    cbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, scan and interpolation datapath.
    cbf_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .step_hz         (step_reg),
        .amplitude       (amplitude),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .lower_cutoff_hz (lower_cutoff_hz),
        .upper_cutoff_hz (upper_cutoff_hz),
        .lower_found     (lower_found),
        .upper_found     (upper_found),
        .peak_index      (peak_index),
        .peak_value      (peak_value)
    );

endmodule
